/* sv/backspace_edit_compare_top_assert.svh */
// assertion macros for the backspace edit compare block
`ifndef BACKSPACE_EDIT_COMPARE_TOP_ASSERT_SVH
`define BACKSPACE_EDIT_COMPARE_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// property that must hold at every clock edge outside reset
`define BEC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// condition that must never be seen outside reset
`define BEC_ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define BEC_ASSERT(label, prop, msg)
`define BEC_ASSERT_NEVER(label, expr, msg)
`endif

`endif

/* sv/bec_pkg.sv */
// shared types and constants for the backspace edit compare block
`timescale 1ns / 1ps

package bec_pkg;

  localparam int CHAR_W = 8;
  localparam int KIND_W = 2;

  localparam logic [KIND_W-1:0] KIND_A   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_B   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CMP = 2'd2;

  localparam logic [CHAR_W-1:0] ERASE_RESET = 8'd35;

  typedef enum logic {
    S_IDLE,
    S_WALK
  } state_t;

  typedef struct packed {
    logic edit_a;
    logic edit_b;
    logic cmp_start;
    logic walk;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic walk_done;
  } sts_t;

endpackage

/* sv/bec_in_if.sv */
// input channel: kind and character
`timescale 1ns / 1ps

interface bec_in_if
  import bec_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [CHAR_W-1:0] ch;

  modport source (output valid, output kind, output ch, input ready);
  modport sink   (input valid, input kind, input ch, output ready);
endinterface

/* sv/bec_out_if.sv */
// output channel: compare result
`timescale 1ns / 1ps

interface bec_out_if;
  logic valid;
  logic ready;
  logic equal;
  logic overflowed;

  modport source (output valid, output equal, output overflowed, input ready);
  modport sink   (input valid, input equal, input overflowed, output ready);
endinterface

/* sv/bec_ctrl.sv */
// controller: input acceptance, compare walk sequencing and result valid
`timescale 1ns / 1ps

module bec_ctrl
  import bec_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [KIND_W-1:0] in_kind,
  output logic              in_ready,
  input  logic              out_ready,
  output logic              out_valid,
  input  sts_t              sts,
  output cmd_t              cmd
);

  state_t state;
  state_t state_next;
  logic   slot_free;
  logic   accept;

  assign slot_free = !out_valid || out_ready;
  assign accept    = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && in_kind == KIND_CMP) begin
          state_next = S_WALK;
        end
      end
      S_WALK: begin
        if (sts.walk_done && slot_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    case (state)
      S_IDLE: begin
        in_ready      = 1'b1;
        cmd.edit_a    = accept && in_kind == KIND_A;
        cmd.edit_b    = accept && in_kind == KIND_B;
        cmd.cmp_start = accept && in_kind == KIND_CMP;
      end
      S_WALK: begin
        cmd.walk   = 1'b1;
        cmd.finish = sts.walk_done && slot_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

/* sv/bec_dp.sv */
// datapath: two edit stacks, depths, overflow flag and compare walk
`timescale 1ns / 1ps

module bec_dp
  import bec_pkg::*;
#(
  parameter int STACK_DEPTH = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [CHAR_W-1:0] cfg_wdata,
  input  logic [CHAR_W-1:0] in_ch,
  input  cmd_t              cmd,
  output sts_t              sts,
  output logic              equal,
  output logic              overflowed
);

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam logic [CW-1:0] FULL = CW'(STACK_DEPTH);

  logic [CHAR_W-1:0] mem_a [STACK_DEPTH];
  logic [CHAR_W-1:0] mem_b [STACK_DEPTH];

  logic [CHAR_W-1:0] erase_code;
  logic [CW-1:0]     depth_a;
  logic [CW-1:0]     depth_b;
  logic              ovf;
  logic [CW-1:0]     rd_idx;
  logic              rd_vld;
  logic [CHAR_W-1:0] rd_a;
  logic [CHAR_W-1:0] rd_b;
  logic              same;

  logic is_erase;
  logic push_a;
  logic push_b;
  logic rd_en;

  assign is_erase = in_ch == erase_code;
  assign push_a   = cmd.edit_a && !is_erase && depth_a != FULL;
  assign push_b   = cmd.edit_b && !is_erase && depth_b != FULL;
  assign rd_en    = cmd.walk && same && rd_idx != depth_a;

  assign sts.walk_done = !rd_vld && (!same || rd_idx == depth_a);

  always_ff @(posedge clk) begin
    if (rst) begin
      erase_code <= ERASE_RESET;
    end else if (cfg_we) begin
      erase_code <= cfg_wdata;
    end
  end

  // stack storage, one write and one registered read port each
  always_ff @(posedge clk) begin
    if (push_a) begin
      mem_a[depth_a[AW-1:0]] <= in_ch;
    end
    if (push_b) begin
      mem_b[depth_b[AW-1:0]] <= in_ch;
    end
    if (rd_en) begin
      rd_a <= mem_a[rd_idx[AW-1:0]];
      rd_b <= mem_b[rd_idx[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      depth_a <= '0;
      depth_b <= '0;
      ovf     <= 1'b0;
      rd_idx  <= '0;
      rd_vld  <= 1'b0;
      same    <= 1'b0;
    end else begin
      rd_vld <= rd_en;
      if (cmd.finish) begin
        depth_a <= '0;
        depth_b <= '0;
        ovf     <= 1'b0;
      end else begin
        if (cmd.edit_a) begin
          if (is_erase) begin
            if (depth_a != '0) depth_a <= depth_a - CW'(1);
          end else if (push_a) begin
            depth_a <= depth_a + CW'(1);
          end else begin
            ovf <= 1'b1;
          end
        end
        if (cmd.edit_b) begin
          if (is_erase) begin
            if (depth_b != '0) depth_b <= depth_b - CW'(1);
          end else if (push_b) begin
            depth_b <= depth_b + CW'(1);
          end else begin
            ovf <= 1'b1;
          end
        end
      end
      if (cmd.cmp_start) begin
        rd_idx <= '0;
        same   <= depth_a == depth_b;
      end else begin
        if (rd_en) rd_idx <= rd_idx + CW'(1);
        if (rd_vld && rd_a != rd_b) same <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      equal      <= same;
      overflowed <= ovf;
    end
  end

endmodule

/* sv/backspace_edit_compare_top.sv */
// top level of the backspace edit compare block
`timescale 1ns / 1ps

// Two edit streams, A and B, each kept as a stack of up to STACK_DEPTH
// characters. A character transfer tagged for a stream pops that stream's
// stack when it matches the erase code register (reset value '#', 35) and
// is ignored on an empty stack; any other character is pushed, or dropped
// with the sticky overflow flag set when the stack is full. A compare
// transfer yields one result: equal is 1 when both stacks have the same
// length and contents, overflowed reports the sticky flag, and then both
// stacks and the flag are cleared. Kind code 3 is accepted and ignored.
// Character transfers may follow back to back while idle. A compare holds
// off input while it walks the stacks through the single registered read
// port of each stack memory: it reads nothing when the lengths differ,
// otherwise it reads the pairs in order, ending early after the first
// mismatching pair. The result waits in an output register; a following
// compare can only finish once that register has been taken, character
// transfers go on meanwhile. The user must write the erase code through
// cfg_we / cfg_wdata only while idle; the block does not enforce this.

module backspace_edit_compare_top
  import bec_pkg::*;
#(
  parameter int STACK_DEPTH = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [CHAR_W-1:0] cfg_wdata,
  bec_in_if.sink            in_ch,
  bec_out_if.source         out_ch
);

`include "backspace_edit_compare_top_assert.svh"

  cmd_t cmd;
  sts_t sts;

  // sequencing of acceptance, compare walk and result hand-off
  bec_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_kind   (in_ch.kind),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  // stacks, depth counters, overflow flag and result payload
  bec_dp #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_ch      (in_ch.ch),
    .cmd        (cmd),
    .sts        (sts),
    .equal      (out_ch.equal),
    .overflowed (out_ch.overflowed)
  );

  // no input transfer while a compare walk owns the stacks
  `BEC_ASSERT_NEVER(a_no_input_in_walk, cmd.walk && in_ch.ready, "input ready during walk")
  // a finished compare is presented on the next cycle
  `BEC_ASSERT(a_finish_shows_result, cmd.finish |=> out_ch.valid, "result not presented")
  // a compare only finishes into a free output register
  `BEC_ASSERT(a_no_result_overwrite, cmd.finish |-> (!out_ch.valid || out_ch.ready),
    "pending result overwritten")

endmodule
